### hdl/lgfw_pkg.sv
// ----------------------------------------------------------------------------
// lgfw_pkg
// Shared types and constants for the linear gradient fade-to-white block.
// ----------------------------------------------------------------------------
package lgfw_pkg;

  localparam int POS_W    = 12;   // pixel / point coordinate
  localparam int DIM_W    = 13;   // image size register
  localparam int CHAN_W   = 8;    // one channel byte
  localparam int NUM_CHAN = 3;    // channel fields per item
  localparam int CFG_W    = 13;   // config write data, widest register
  localparam int ADDR_W   = 3;    // config register index
  localparam int DIFF_W   = POS_W + 1;       // signed coordinate difference
  localparam int FAR_W    = DIM_W + 1;       // signed far-corner offset
  localparam int PROD_W   = DIFF_W + FAR_W;  // one projection product
  localparam int DIST_W   = PROD_W + 1;      // signed projection sum
  localparam int MAG_W    = DIST_W - 1;      // projection magnitude
  localparam int QUOT_W   = CHAN_W;          // fade quotient bits
  localparam int NUM_W    = CHAN_W + MAG_W;  // dividend (255-c)*d
  // lane pipeline: product register, one register per quotient bit, output
  localparam int LANE_LAT = QUOT_W + 2;

  localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;

  typedef enum logic [ADDR_W-1:0] {
    REG_START_X    = 3'd0,
    REG_START_Y    = 3'd1,
    REG_END_X      = 3'd2,
    REG_END_Y      = 3'd3,
    REG_IMAGE_COLS = 3'd4,
    REG_IMAGE_ROWS = 3'd5,
    REG_COLOR_MODE = 3'd6
  } lgfw_reg_t;

  typedef struct packed {
    logic [POS_W-1:0]  pos_x;
    logic [POS_W-1:0]  pos_y;
    logic [CHAN_W-1:0] chan0_in;
    logic [CHAN_W-1:0] chan1_in;
    logic [CHAN_W-1:0] chan2_in;
  } lgfw_in_t;

  typedef struct packed {
    logic [CHAN_W-1:0] chan0_out;
    logic [CHAN_W-1:0] chan1_out;
    logic [CHAN_W-1:0] chan2_out;
  } lgfw_out_t;

  // per-channel control that rides along with an item
  typedef struct packed {
    logic blank;  // channel unused in gray mode, output zero
    logic fade;   // projection positive and greatest projection nonzero
    logic sat;    // projection at or beyond the greatest: output 255 when fade is set
  } lgfw_ctl_t;

endpackage

### hdl/lgfw_lane.sv
// ----------------------------------------------------------------------------
// lgfw_lane
// One channel: c + floor((255-c)*d/m) when fading, else c, zero or 255 as ctl says;
// pipelined restoring divide, one quotient bit per stage.
// ----------------------------------------------------------------------------
module lgfw_lane (
  input  logic                         clk,
  input  logic [lgfw_pkg::CHAN_W-1:0]  c,
  input  logic [lgfw_pkg::MAG_W-1:0]   dmag,
  input  logic [lgfw_pkg::MAG_W-1:0]   m,
  input  lgfw_pkg::lgfw_ctl_t          ctl,
  output logic [lgfw_pkg::CHAN_W-1:0]  y
);
  import lgfw_pkg::*;

  logic [NUM_W-1:0]  rem  [QUOT_W+1];
  logic [QUOT_W-1:0] quo  [QUOT_W+1];
  logic [CHAN_W-1:0] chan [QUOT_W+1];
  lgfw_ctl_t         ct   [QUOT_W+1];

  // dividend; d < m on the fade path unless sat is set, so the quotient fits in 8 bits
  always_ff @(posedge clk) begin
    rem[0]  <= NUM_W'(CHAN_MAX - c) * NUM_W'(dmag);
    quo[0]  <= '0;
    chan[0] <= c;
    ct[0]   <= ctl;
  end

  for (genvar s = 0; s < QUOT_W; s++) begin : g_div
    localparam int BIT = QUOT_W - 1 - s;
    logic [NUM_W-1:0] dsh;
    logic [NUM_W:0]   diff;

    assign dsh  = NUM_W'(m) << BIT;
    assign diff = {1'b0, rem[s]} - {1'b0, dsh};

    always_ff @(posedge clk) begin
      if (!diff[NUM_W]) begin
        rem[s+1] <= diff[NUM_W-1:0];
        quo[s+1] <= quo[s] | QUOT_W'(1 << BIT);
      end else begin
        rem[s+1] <= rem[s];
        quo[s+1] <= quo[s];
      end
      chan[s+1] <= chan[s];
      ct[s+1]   <= ct[s];
    end
  end

  // c + q never exceeds 255 when d < m
  always_ff @(posedge clk) begin
    priority if (ct[QUOT_W].blank) begin
      y <= '0;
    end else if (ct[QUOT_W].fade && ct[QUOT_W].sat) begin
      y <= CHAN_MAX;
    end else if (ct[QUOT_W].fade) begin
      y <= chan[QUOT_W] + quo[QUOT_W];
    end else begin
      y <= chan[QUOT_W];
    end
  end

endmodule

### hdl/linear_gradient_fade_to_white.sv
// ----------------------------------------------------------------------------
// linear_gradient_fade_to_white
// Fades pixels toward white along a configured gradient direction.
// ----------------------------------------------------------------------------
//
//  Channel  Ports                      Handshake
//  -------  -------------------------  -----------------------------------
//  input    start, busy, item          item taken when start && !busy
//  result   done, result               one-cycle strobe, cannot be held off
//  config   cfg_we, cfg_addr, cfg_wdata  written when cfg_we, no wait
//
//  One item per clock while busy is low. From accept to done the item
//  passes five projection stages (capture, offsets, products, sum,
//  compare) and ten lane stages (dividend product, eight quotient-bit
//  stages, output). The eight-bit restoring divide sets the depth.
//  busy is a registered copy of rst: high through reset and for the cycle
//  after it. Synchronous reset clears the valid bits and loads the config
//  defaults. Nothing stalls; results leave exactly as items entered.
//
module linear_gradient_fade_to_white #(
  parameter int LANES = 3   // channels with a fade lane, 1..3
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  lgfw_pkg::lgfw_in_t                item,
  output logic                              busy,
  output logic                              done,
  output lgfw_pkg::lgfw_out_t               result,
  input  logic                              cfg_we,
  input  logic [lgfw_pkg::ADDR_W-1:0]       cfg_addr,
  input  logic [lgfw_pkg::CFG_W-1:0]        cfg_wdata
);
  import lgfw_pkg::*;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [POS_W-1:0] start_x, start_y, end_x, end_y;
  logic [DIM_W-1:0] image_cols, image_rows;
  logic             color_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_x    <= POS_W'(0);
      start_y    <= POS_W'(0);
      end_x      <= POS_W'(1);
      end_y      <= POS_W'(0);
      image_cols <= DIM_W'(640);
      image_rows <= DIM_W'(480);
      color_mode <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_START_X:    start_x    <= cfg_wdata[POS_W-1:0];
        REG_START_Y:    start_y    <= cfg_wdata[POS_W-1:0];
        REG_END_X:      end_x      <= cfg_wdata[POS_W-1:0];
        REG_END_Y:      end_y      <= cfg_wdata[POS_W-1:0];
        REG_IMAGE_COLS: image_cols <= cfg_wdata[DIM_W-1:0];
        REG_IMAGE_ROWS: image_rows <= cfg_wdata[DIM_W-1:0];
        REG_COLOR_MODE: color_mode <= cfg_wdata[0];
        default: ;  // unknown index ignored
      endcase
    end
  end

  // busy through reset and right after it, so the derived terms below settle
  always_ff @(posedge clk) begin
    busy <= rst;
  end

  // --------------------------------------------------------------------------
  // Derived terms, up to three register stages behind the config registers.
  // Config must only change while empty; the block does not enforce it. A
  // new item reaches the compare stage after these have settled.
  // --------------------------------------------------------------------------
  logic signed [DIFF_W-1:0] dx_c, dy_c;
  logic [DIM_W-1:0]         fx_c, fy_c;
  logic signed [DIFF_W-1:0] dx_q, dy_q;
  logic signed [FAR_W-1:0]  farx_q, fary_q;
  logic signed [PROD_W-1:0] mpx_q, mpy_q;
  logic signed [DIST_W-1:0] msum;
  logic [MAG_W-1:0]         mag_q;

  assign dx_c = $signed({1'b0, end_x}) - $signed({1'b0, start_x});
  assign dy_c = $signed({1'b0, end_y}) - $signed({1'b0, start_y});
  // far corner picked by the direction signs
  assign fx_c = (dx_c > 0) ? image_cols : '0;
  assign fy_c = (dy_c > 0) ? image_rows : '0;
  assign msum = DIST_W'(mpx_q) + DIST_W'(mpy_q);

  always_ff @(posedge clk) begin
    dx_q   <= dx_c;
    dy_q   <= dy_c;
    farx_q <= $signed({1'b0, fx_c}) - $signed({2'b0, start_x});
    fary_q <= $signed({1'b0, fy_c}) - $signed({2'b0, start_y});
    mpx_q  <= PROD_W'(dx_q) * PROD_W'(farx_q);
    mpy_q  <= PROD_W'(dy_q) * PROD_W'(fary_q);
    mag_q  <= (msum < 0) ? MAG_W'(-msum) : MAG_W'(msum);
  end

  // --------------------------------------------------------------------------
  // Projection pipeline
  // --------------------------------------------------------------------------
  localparam int PRE = 5;   // capture .. compare
  localparam int LAT = PRE + LANE_LAT;

  logic [LAT-1:0] vld;      // vld[k]: item held after stage k+1

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LAT-2:0], start && !busy};
    end
  end

  lgfw_in_t                 in1, in2, in3, in4;
  logic signed [DIFF_W-1:0] rx2, ry2;
  logic signed [PROD_W-1:0] px3, py3;
  logic signed [DIST_W-1:0] d4;
  logic [MAG_W-1:0]         dmag5;
  logic [CHAN_W-1:0]        chan5 [NUM_CHAN];
  lgfw_ctl_t                ctl5  [NUM_CHAN];
  logic [CHAN_W-1:0]        chan_y [NUM_CHAN];

  always_ff @(posedge clk) begin
    // stage 1: capture
    in1 <= item;
    // stage 2: offsets from the start point
    in2 <= in1;
    rx2 <= $signed({1'b0, in1.pos_x}) - $signed({1'b0, start_x});
    ry2 <= $signed({1'b0, in1.pos_y}) - $signed({1'b0, start_y});
    // stage 3: products
    in3 <= in2;
    px3 <= PROD_W'(dx_q) * PROD_W'(rx2);
    py3 <= PROD_W'(dy_q) * PROD_W'(ry2);
    // stage 4: projection
    in4 <= in3;
    d4  <= DIST_W'(px3) + DIST_W'(py3);
    // stage 5: compare against the greatest projection
    dmag5    <= d4[MAG_W-1:0];
    chan5[0] <= in4.chan0_in;
    chan5[1] <= in4.chan1_in;
    chan5[2] <= in4.chan2_in;
    for (int n = 0; n < NUM_CHAN; n++) begin
      ctl5[n].blank <= (n > 0) && !color_mode;
      ctl5[n].fade  <= (d4 > 0) && (mag_q != '0);
      ctl5[n].sat   <= d4 >= $signed(DIST_W'(mag_q));
    end
  end

  // --------------------------------------------------------------------------
  // Channel lanes; channels beyond LANES, zeroed when blank, pass through a delay line
  // --------------------------------------------------------------------------
  for (genvar n = 0; n < NUM_CHAN; n++) begin : g_chan
    if (n < LANES) begin : g_lane
      lgfw_lane u_lane (
        .clk  (clk),
        .c    (chan5[n]),
        .dmag (dmag5),
        .m    (mag_q),
        .ctl  (ctl5[n]),
        .y    (chan_y[n])
      );
    end else begin : g_pass
      logic [CHAN_W-1:0] dly [LANE_LAT];
      always_ff @(posedge clk) begin
        dly[0] <= ctl5[n].blank ? '0 : chan5[n];
        for (int k = 1; k < LANE_LAT; k++) begin
          dly[k] <= dly[k-1];
        end
      end
      assign chan_y[n] = dly[LANE_LAT-1];
    end
  end

  assign done             = vld[LAT-1];
  assign result.chan0_out = chan_y[0];
  assign result.chan1_out = chan_y[1];
  assign result.chan2_out = chan_y[2];

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the gradient fade-to-white pixel pipeline: a table
// of directed pixels and register writes, then random register settings with
// random pixel traffic, each result checked against a typed-in value or a local predictor.
// ----------------------------------------------------------------------------
module tb_top;
  import lgfw_pkg::*;

  localparam int FADE_LANES = 3;
  localparam int DRAIN_CYCLES = 20;   // pipeline is 15 deep
  localparam int RAND_PHASES = 10;
  localparam int PHASE_ITEMS = 100;
  localparam logic [ADDR_W-1:0] REG_NONE = 3'd7;   // unmapped index

  // ---------------------------------------------------------------------------
  // Clock, reset and DUT inputs (all known from time zero)
  // ---------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  lgfw_in_t item = '0;
  logic cfg_we = 1'b0;
  logic [ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;
  logic busy;
  logic done;
  lgfw_out_t result;

  always #5 clk = ~clk;

  linear_gradient_fade_to_white #(
    .LANES(FADE_LANES)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .item(item),
    .busy(busy),
    .done(done),
    .result(result),
    .cfg_we(cfg_we),
    .cfg_addr(cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  // ---------------------------------------------------------------------------
  // Local copy of the register file, updated as writes land
  // ---------------------------------------------------------------------------
  logic [POS_W-1:0] cur_sx = '0;
  logic [POS_W-1:0] cur_sy = '0;
  logic [POS_W-1:0] cur_ex = 12'd1;
  logic [POS_W-1:0] cur_ey = '0;
  logic [DIM_W-1:0] cur_cols = 13'd640;
  logic [DIM_W-1:0] cur_rows = 13'd480;
  logic cur_color = 1'b1;

  lgfw_out_t expected_pixels[$];
  int unsigned mismatch_count = 0;

  // ---------------------------------------------------------------------------
  // Predictor: projection of the pixel onto the gradient direction, scaled
  // by the projection at the far corner, blends each channel toward white.
  // ---------------------------------------------------------------------------
  function automatic lgfw_out_t faded_pixel(input lgfw_in_t p);
    longint sx, sy, dx, dy, fx, fy, m, d, num, q;
    logic [CHAN_W-1:0] chin [NUM_CHAN];
    logic [CHAN_W-1:0] chout [NUM_CHAN];
    int nch;
    lgfw_out_t o;
    sx = longint'(cur_sx);
    sy = longint'(cur_sy);
    dx = longint'(cur_ex) - sx;
    dy = longint'(cur_ey) - sy;
    // far corner picked by direction signs
    fx = (dx > 0) ? longint'(cur_cols) : 0;
    fy = (dy > 0) ? longint'(cur_rows) : 0;
    m = dy * (fy - sy) + dx * (fx - sx);
    if (m < 0) m = -m;
    d = dy * (longint'(p.pos_y) - sy) + dx * (longint'(p.pos_x) - sx);
    chin[0] = p.chan0_in;
    chin[1] = p.chan1_in;
    chin[2] = p.chan2_in;
    nch = cur_color ? NUM_CHAN : 1;
    for (int n = 0; n < NUM_CHAN; n++) begin
      if (n >= nch) begin
        chout[n] = '0;                       // unused in gray mode
      end else if (d > 0 && m > 0 && n < FADE_LANES) begin
        num = longint'(chin[n]) * (m - d) + longint'(CHAN_MAX) * d;
        if (num < 0) num = 0;
        q = num / m;                         // truncating
        chout[n] = (q > longint'(CHAN_MAX)) ? CHAN_MAX : CHAN_W'(q);
      end else begin
        chout[n] = chin[n];                  // behind the start line, zero greatest projection, or no fade lane
      end
    end
    o.chan0_out = chout[0];
    o.chan1_out = chout[1];
    o.chan2_out = chout[2];
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker: every done strobe is matched to the oldest expectation.
  // Sampling at the edge sees pre-edge values of done/result.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    lgfw_out_t want;
    if (!rst && done) begin
      if (expected_pixels.size() == 0) begin
        $error("unexpected result item: %h", result);
        mismatch_count++;
      end else begin
        want = expected_pixels.pop_front();
        if (result.chan0_out !== want.chan0_out) begin
          $error("chan0_out: expected %0d, actual %0d", want.chan0_out, result.chan0_out);
          mismatch_count++;
        end
        if (result.chan1_out !== want.chan1_out) begin
          $error("chan1_out: expected %0d, actual %0d", want.chan1_out, result.chan1_out);
          mismatch_count++;
        end
        if (result.chan2_out !== want.chan2_out) begin
          $error("chan2_out: expected %0d, actual %0d", want.chan2_out, result.chan2_out);
          mismatch_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  // Register write; cfg_we stays high across back-to-back writes,
  // send_pixel drops it.
  task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [CFG_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= data;
    @(posedge clk);
    case (addr)
      REG_START_X:    cur_sx = data[POS_W-1:0];
      REG_START_Y:    cur_sy = data[POS_W-1:0];
      REG_END_X:      cur_ex = data[POS_W-1:0];
      REG_END_Y:      cur_ey = data[POS_W-1:0];
      REG_IMAGE_COLS: cur_cols = data[DIM_W-1:0];
      REG_IMAGE_ROWS: cur_rows = data[DIM_W-1:0];
      REG_COLOR_MODE: cur_color = data[0];
      default: ;                            // unmapped, no effect
    endcase
  endtask

  // Hold off new items until the pipeline has emptied.
  task automatic drain_pipe();
    if (start) start <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
  endtask

  // One pixel item; start stays high into the next item when gap is zero.
  task automatic send_pixel(input lgfw_in_t pix, input logic typed,
                            input lgfw_out_t want, input int unsigned gap);
    cfg_we <= 1'b0;
    start <= 1'b1;
    item <= pix;
    do @(posedge clk); while (busy);
    expected_pixels.push_back(typed ? want : faded_pixel(pix));
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic [CFG_W-1:0] rand_coord();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return 13'd4095;
      2: return CFG_W'($urandom_range(0, 8191));   // upper bit is dropped
      default: return CFG_W'($urandom_range(0, 4095));
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] rand_dim();
    case ($urandom_range(0, 7))
      0: return 13'd1;
      1: return 13'd4096;
      2: return CFG_W'($urandom_range(0, 8191));   // zero and oversize too
      default: return CFG_W'($urandom_range(1, 4096));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Directed table: pixels and register writes in order. Typed-in results
  // only where obvious; other pixel rows go through the predictor.
  // ---------------------------------------------------------------------------
  typedef enum logic {ROW_PIX, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t         kind;
    logic [ADDR_W-1:0] addr;
    logic [CFG_W-1:0]  wdata;
    lgfw_in_t          pix;
    logic              typed;
    lgfw_out_t         want;
  } dir_row_t;

  localparam int DIR_ROWS = 38;
  localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
    // reset setting: horizontal gradient, far corner at column 640
    '{ROW_PIX, 3'd0, 13'd0, '{12'd0, 12'd0, 8'd0, 8'd0, 8'd0}, 1'b1, '{8'd0, 8'd0, 8'd0}},
    '{ROW_PIX, 3'd0, 13'd0, '{12'd0, 12'd4095, 8'd255, 8'd255, 8'd255}, 1'b1,
      '{8'd255, 8'd255, 8'd255}},
    '{ROW_PIX, 3'd0, 13'd0, '{12'd640, 12'd0, 8'd0, 8'd0, 8'd0}, 1'b1,
      '{8'd255, 8'd255, 8'd255}},
    '{ROW_PIX, 3'd0, 13'd0, '{12'd4095, 12'd4095, 8'd0, 8'd128, 8'd255}, 1'b1,
      '{8'd255, 8'd255, 8'd255}},
    '{ROW_PIX, 3'd0, 13'd0, '{12'd320, 12'd100, 8'd0, 8'd100, 8'd200}, 1'b0, '0},
    '{ROW_PIX, 3'd0, 13'd0, '{12'd1, 12'd0, 8'd255, 8'd0, 8'd17}, 1'b0, '0},
    // gray mode
    '{ROW_CFG, REG_COLOR_MODE, 13'd0, '0, 1'b0, '0},
    '{ROW_PIX, 3'd0, 13'd0, '{12'd320, 12'd0, 8'd10, 8'd200, 8'd255}, 1'b0, '0},
    '{ROW_PIX, 3'd0, 13'd0, '{12'd0, 12'd0, 8'd77, 8'd200, 8'd255}, 1'b1, '{8'd77, 8'd0, 8'd0}},
    // equal start and end: pass-through everywhere
    '{ROW_CFG, REG_COLOR_MODE, 13'd1, '0, 1'b0, '0},
    '{ROW_CFG, REG_START_X, 13'd100, '0, 1'b0, '0},
    '{ROW_CFG, REG_START_Y, 13'd100, '0, 1'b0, '0},
    '{ROW_CFG, REG_END_X, 13'd100, '0, 1'b0, '0},
    '{ROW_CFG, REG_END_Y, 13'd100, '0, 1'b0, '0},
    '{ROW_PIX, 3'd0, 13'd0, '{12'd4095, 12'd4095, 8'd1, 8'd2, 8'd3}, 1'b1, '{8'd1, 8'd2, 8'd3}},
    '{ROW_PIX, 3'd0, 13'd0, '{12'd0, 12'd0, 8'd250, 8'd251, 8'd252}, 1'b1,
      '{8'd250, 8'd251, 8'd252}},
    // negative direction, far corner at the origin
    '{ROW_CFG, REG_START_X, 13'd4095, '0, 1'b0, '0},
    '{ROW_CFG, REG_START_Y, 13'd4095, '0, 1'b0, '0},
    '{ROW_CFG, REG_END_X, 13'd0, '0, 1'b0, '0},
    '{ROW_CFG, REG_END_Y, 13'd0, '0, 1'b0, '0},
    '{ROW_PIX, 3'd0, 13'd0, '{12'd0, 12'd0, 8'd0, 8'd0, 8'd0}, 1'b1, '{8'd255, 8'd255, 8'd255}},
    '{ROW_PIX, 3'd0, 13'd0, '{12'd4095, 12'd4095, 8'd9, 8'd8, 8'd7}, 1'b1, '{8'd9, 8'd8, 8'd7}},
    '{ROW_PIX, 3'd0, 13'd0, '{12'd2047, 12'd1000, 8'd50, 8'd60, 8'd70}, 1'b0, '0},
    // far corner column equals start column: zero greatest projection
    '{ROW_CFG, REG_START_X, 13'd5, '0, 1'b0, '0},
    '{ROW_CFG, REG_START_Y, 13'd0, '0, 1'b0, '0},
    '{ROW_CFG, REG_END_X, 13'd10, '0, 1'b0, '0},
    '{ROW_CFG, REG_IMAGE_COLS, 13'd5, '0, 1'b0, '0},
    '{ROW_PIX, 3'd0, 13'd0, '{12'd100, 12'd3, 8'd40, 8'd50, 8'd60}, 1'b1, '{8'd40, 8'd50, 8'd60}},
    // diagonal, oversize image, top data bit dropped on 12-bit registers
    '{ROW_CFG, REG_START_X, 13'd0, '0, 1'b0, '0},
    '{ROW_CFG, REG_START_Y, 13'h1000, '0, 1'b0, '0},
    '{ROW_CFG, REG_END_X, 13'h1fff, '0, 1'b0, '0},
    '{ROW_CFG, REG_END_Y, 13'd4095, '0, 1'b0, '0},
    '{ROW_CFG, REG_IMAGE_COLS, 13'd8191, '0, 1'b0, '0},
    '{ROW_CFG, REG_IMAGE_ROWS, 13'd4096, '0, 1'b0, '0},
    '{ROW_PIX, 3'd0, 13'd0, '{12'd4095, 12'd4095, 8'd0, 8'd0, 8'd0}, 1'b0, '0},
    '{ROW_PIX, 3'd0, 13'd0, '{12'd1, 12'd1, 8'd255, 8'd0, 8'd128}, 1'b0, '0},
    // unmapped register index must change nothing
    '{ROW_CFG, REG_NONE, 13'd8191, '0, 1'b0, '0},
    '{ROW_PIX, 3'd0, 13'd0, '{12'd2000, 12'd2000, 8'd3, 8'd4, 8'd5}, 1'b0, '0}
  };

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    dir_row_t row;
    lgfw_in_t pix;
    logic burst;
    int unsigned gap;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed part
    for (int i = 0; i < DIR_ROWS; i++) begin
      row = DIR_TAB[i];
      if (row.kind == ROW_CFG) begin
        drain_pipe();
        write_reg(row.addr, row.wdata);
      end else begin
        send_pixel(row.pix, row.typed, row.want, $urandom_range(0, 7));
      end
    end

    // random part: a fresh register setting per phase
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      drain_pipe();
      write_reg(REG_START_X, rand_coord());
      write_reg(REG_START_Y, rand_coord());
      if ($urandom_range(0, 7) == 0) begin
        // degenerate direction
        write_reg(REG_END_X, CFG_W'(cur_sx));
        write_reg(REG_END_Y, CFG_W'(cur_sy));
      end else begin
        write_reg(REG_END_X, rand_coord());
        write_reg(REG_END_Y, rand_coord());
      end
      write_reg(REG_IMAGE_COLS, rand_dim());
      write_reg(REG_IMAGE_ROWS, rand_dim());
      write_reg(REG_COLOR_MODE, CFG_W'($urandom));
      if ($urandom_range(0, 3) == 0) write_reg(REG_NONE, CFG_W'($urandom));

      burst = ($urandom_range(0, 2) == 0);   // back-to-back stretch
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        pix.pos_x = POS_W'($urandom_range(0, 4095));
        pix.pos_y = POS_W'($urandom_range(0, 4095));
        pix.chan0_in = CHAN_W'($urandom);
        pix.chan1_in = CHAN_W'($urandom);
        pix.chan2_in = CHAN_W'($urandom);
        if ($urandom_range(0, 3) == 0) begin
          // around the start point, where the projection changes sign
          pix.pos_x = cur_sx + POS_W'($urandom_range(0, 2)) - 12'd1;
          pix.pos_y = cur_sy + POS_W'($urandom_range(0, 2)) - 12'd1;
        end
        if ($urandom_range(0, 7) == 0) pix.chan0_in = CHAN_MAX;
        gap = burst ? 0 : $urandom_range(0, 7);
        send_pixel(pix, 1'b0, '0, gap);
        // occasional full drain mid-phase
        if ($urandom_range(0, 63) == 0) drain_pipe();
      end
    end

    // wind down and report
    drain_pipe();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_pixels.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
